/* hw/rtl/etl_pkg.sv */
`timescale 1ns / 1ps
// Package for the expression token lexer: beat types, token kinds, lexer state
// codes and the character classifiers. No dependencies.
package etl_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int MAX_RESULTS           = 3;
    localparam int RES_CNT_BITS          = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH           = 4;
    localparam int QPTR_BITS             = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS             = $clog2(QUEUE_DEPTH + 1);

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_S      = 8'h73;

    typedef enum logic [4:0] {
        KIND_EOF    = 5'd0,
        KIND_BAD    = 5'd1,
        KIND_SPACE  = 5'd2,
        KIND_NUMBER = 5'd3,
        KIND_IDENT  = 5'd4,
        KIND_TRUE   = 5'd5,
        KIND_FALSE  = 5'd6,
        KIND_PLUS   = 5'd7,
        KIND_MINUS  = 5'd8,
        KIND_STAR   = 5'd9,
        KIND_SLASH  = 5'd10,
        KIND_NOT    = 5'd11,
        KIND_ASSIGN = 5'd12,
        KIND_AND    = 5'd13,
        KIND_OR     = 5'd14,
        KIND_EQ     = 5'd15,
        KIND_NE     = 5'd16,
        KIND_LPAREN = 5'd17,
        KIND_RPAREN = 5'd18
    } tok_kind_t;

    typedef enum logic [7:0] {
        PEND_NONE  = 8'b0000_0001,
        PEND_NUM   = 8'b0000_0010,
        PEND_IDENT = 8'b0000_0100,
        PEND_SPACE = 8'b0000_1000,
        PEND_AMP   = 8'b0001_0000,
        PEND_PIPE  = 8'b0010_0000,
        PEND_EQ    = 8'b0100_0000,
        PEND_BANG  = 8'b1000_0000
    } pend_t;

    typedef enum logic [10:0] {
        KW_START = 11'b000_0000_0001,
        KW_T     = 11'b000_0000_0010,
        KW_TR    = 11'b000_0000_0100,
        KW_TRU   = 11'b000_0000_1000,
        KW_TRUE  = 11'b000_0001_0000,
        KW_F     = 11'b000_0010_0000,
        KW_FA    = 11'b000_0100_0000,
        KW_FAL   = 11'b000_1000_0000,
        KW_FALS  = 11'b001_0000_0000,
        KW_FALSE = 11'b010_0000_0000,
        KW_DEAD  = 11'b100_0000_0000
    } kw_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } src_beat_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] start_res;
        logic [15:0] length;
        logic [30:0] value;
        logic        overflow;
        logic        last_of_run;
    } tok_beat_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic kw_t kw_step(kw_t s, logic [7:0] c);
        kw_t r;
        r = KW_DEAD;
        unique case (s)
            KW_START: r = (c == CH_T) ? KW_T : ((c == CH_F) ? KW_F : KW_DEAD);
            KW_T:     r = (c == CH_R) ? KW_TR   : KW_DEAD;
            KW_TR:    r = (c == CH_U) ? KW_TRU  : KW_DEAD;
            KW_TRU:   r = (c == CH_E) ? KW_TRUE : KW_DEAD;
            KW_F:     r = (c == CH_A) ? KW_FA   : KW_DEAD;
            KW_FA:    r = (c == CH_L) ? KW_FAL  : KW_DEAD;
            KW_FAL:   r = (c == CH_S) ? KW_FALS : KW_DEAD;
            KW_FALS:  r = (c == CH_E) ? KW_FALSE : KW_DEAD;
            default:  r = KW_DEAD;
        endcase
        return r;
    endfunction

    function automatic tok_kind_t single_kind(logic [7:0] c);
        tok_kind_t k;
        k = KIND_BAD;
        unique case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            default:   k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic tok_beat_t make_tok(tok_kind_t k, logic [15:0] s, logic [15:0] l,
                                           logic [30:0] v, logic o);
        tok_beat_t t;
        t.kind        = k;
        t.start_res   = s;
        t.length      = l;
        t.value       = v;
        t.overflow    = o;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    function automatic tok_beat_t flush_tok(pend_t pc, kw_t kw, logic [15:0] s, logic [15:0] l,
                                            logic [30:0] acc, logic sat);
        tok_beat_t t;
        t = make_tok(KIND_BAD, s, l, 31'd0, 1'b0);
        unique case (pc)
            PEND_NUM:   t = make_tok(KIND_NUMBER, s, l, acc, sat);
            PEND_IDENT: t.kind = (kw == KW_TRUE) ? KIND_TRUE :
                                 ((kw == KW_FALSE) ? KIND_FALSE : KIND_IDENT);
            PEND_SPACE: t.kind = KIND_SPACE;
            PEND_EQ:    t.kind = KIND_ASSIGN;
            PEND_BANG:  t.kind = KIND_NOT;
            default:    t.kind = KIND_BAD;
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/expression_token_lexer.sv */
`timescale 1ns / 1ps
// Expression token lexer top level: token state registers and a four-entry
// result queue. Depends on etl_pkg.
//
// The lexer takes one source byte per cycle on the byte channel and delivers
// tokens, one per beat, on the tok channel. Each byte is lexed in the cycle it
// is accepted and all the tokens it finishes (up to three) are written into a
// four-entry result queue at once; byte_stall rises while more than one token
// waits, so a byte is taken every cycle as long as the token side takes one
// beat per cycle. Bytes that end a token and start a one-byte token, or that
// end the text, make two or three beats, and the token port then sets the pace
// at one beat per cycle. After the end token every byte is taken and dropped
// until reset.
module expression_token_lexer
    import etl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  src_beat_t byte_data,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_beat_t tok_data
);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] ts_reg, ts_next;
    pend_t                    pend_reg, pend_next;
    logic [30:0]              acc_reg, acc_next;
    logic                     sat_reg, sat_next;
    kw_t                      kw_reg, kw_next;
    logic                     done_reg, done_next;

    tok_beat_t                q_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]     count_reg, count_next;

    tok_beat_t                res [MAX_RESULTS];
    logic [RES_CNT_BITS-1:0]  n;
    logic                     pop;

    logic [7:0]               c;
    logic [POSITION_BITS-1:0] p, p1;
    logic [34:0]              prod;
    logic                     cont;

    assign byte_stall = count_reg > QCNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);
    assign tok_valid  = count_reg != '0;
    assign tok_data   = q_reg[rd_ptr_reg];
    assign pop        = tok_valid && !tok_stall;

    always_comb
    begin
        pos_next  = pos_reg;
        ts_next   = ts_reg;
        pend_next = pend_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        kw_next   = kw_reg;
        done_next = done_reg;
        n         = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end
        c    = byte_data.ch;
        p    = pos_reg;
        p1   = pos_reg + 1'b1;
        prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {31'd0, c[3:0]};
        cont = 1'b0;

        if (byte_valid && !byte_stall && !done_reg)
        begin
            if (c == CH_NUL)
            begin
                if (pend_reg != PEND_NONE)
                begin
                    res[n] = flush_tok(pend_reg, kw_reg, 16'(ts_reg), 16'(p - ts_reg),
                                       acc_reg, sat_reg);
                    n = n + 1'b1;
                end
                res[n] = make_tok(KIND_EOF, 16'(p), 16'd0, 31'd0, 1'b0);
                n = n + 1'b1;
                pend_next = PEND_NONE;
                done_next = 1'b1;
            end
            else
            begin
                unique case (pend_reg)
                    PEND_NUM:
                    begin
                        if (is_digit(c))
                        begin
                            if (prod[34:31] != 4'd0)
                            begin
                                acc_next = VALUE_MAX;
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = prod[30:0];
                            end
                            cont = 1'b1;
                        end
                    end
                    PEND_IDENT:
                    begin
                        if (is_alpha(c))
                        begin
                            kw_next = kw_step(kw_reg, c);
                            cont    = 1'b1;
                        end
                    end
                    PEND_SPACE:
                    begin
                        cont = is_ws(c);
                    end
                    PEND_AMP, PEND_PIPE, PEND_EQ, PEND_BANG:
                    begin
                        if ((pend_reg == PEND_AMP && c == CH_AMP) ||
                            (pend_reg == PEND_PIPE && c == CH_PIPE) ||
                            ((pend_reg == PEND_EQ || pend_reg == PEND_BANG) && c == CH_EQ))
                        begin
                            res[n] = make_tok((pend_reg == PEND_AMP)  ? KIND_AND :
                                              (pend_reg == PEND_PIPE) ? KIND_OR :
                                              (pend_reg == PEND_EQ)   ? KIND_EQ : KIND_NE,
                                              16'(ts_reg), 16'(p1 - ts_reg), 31'd0, 1'b0);
                            n = n + 1'b1;
                            pend_next = PEND_NONE;
                            cont      = 1'b1;
                        end
                    end
                    default:
                    begin
                        cont = 1'b0;
                    end
                endcase

                if (!cont)
                begin
                    if (pend_reg != PEND_NONE)
                    begin
                        res[n] = flush_tok(pend_reg, kw_reg, 16'(ts_reg), 16'(p - ts_reg),
                                           acc_reg, sat_reg);
                        n = n + 1'b1;
                    end
                    ts_next   = p;
                    pend_next = PEND_NONE;
                    if (is_digit(c))
                    begin
                        pend_next = PEND_NUM;
                        acc_next  = {27'd0, c[3:0]};
                        sat_next  = 1'b0;
                    end
                    else if (is_alpha(c))
                    begin
                        pend_next = PEND_IDENT;
                        kw_next   = kw_step(KW_START, c);
                    end
                    else if (is_ws(c))
                    begin
                        pend_next = PEND_SPACE;
                    end
                    else if (c == CH_AMP)
                    begin
                        pend_next = PEND_AMP;
                    end
                    else if (c == CH_PIPE)
                    begin
                        pend_next = PEND_PIPE;
                    end
                    else if (c == CH_EQ)
                    begin
                        pend_next = PEND_EQ;
                    end
                    else if (c == CH_BANG)
                    begin
                        pend_next = PEND_BANG;
                    end
                    else
                    begin
                        res[n] = make_tok(single_kind(c), 16'(p), 16'd1, 31'd0, 1'b0);
                        n = n + 1'b1;
                    end
                end

                pos_next = p1;

                if (byte_data.end_of_text)
                begin
                    if (pend_next != PEND_NONE)
                    begin
                        res[n] = flush_tok(pend_next, kw_next, 16'(ts_next),
                                           16'(p1 - ts_next), acc_next, sat_next);
                        n = n + 1'b1;
                    end
                    res[n] = make_tok(KIND_EOF, 16'(p1), 16'd0, 31'd0, 1'b0);
                    n = n + 1'b1;
                    pend_next = PEND_NONE;
                    done_next = 1'b1;
                end
            end
            if (n != '0)
            begin
                res[n - 1'b1].last_of_run = 1'b1;
            end
        end

        count_next = count_reg + QCNT_BITS'(n) - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ts_reg     <= '0;
            pend_reg   <= PEND_NONE;
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            kw_reg     <= KW_START;
            done_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            ts_reg     <= ts_next;
            pend_reg   <= pend_next;
            acc_reg    <= acc_next;
            sat_reg    <= sat_next;
            kw_reg     <= kw_next;
            done_reg   <= done_next;
            wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (i < int'(n))
            begin
                q_reg[wr_ptr_reg + QPTR_BITS'(i)] <= res[i];
            end
        end
    end

endmodule

/* hw/rtl/etl_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the expression token lexer and the bind that attaches
// them to the top level. Depends on etl_pkg and expression_token_lexer.
module etl_checker
    import etl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_stall,
    input src_beat_t byte_data,
    input logic      tok_valid,
    input logic      tok_stall,
    input tok_beat_t tok_data
);

    // hold a stalled token beat
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_data))
        else $error("token beat changed while stalled");

    // the rest of a run follows without a gap
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_stall && !tok_data.last_of_run |=> tok_valid)
        else $error("token run broken before its last beat");

    // nothing follows the end token
    a_eof_final: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_stall && tok_data.kind == KIND_EOF |=> !tok_valid)
        else $error("token delivered after end of text");

endmodule

bind expression_token_lexer etl_checker u_etl_checker (.*);
